@@ hdl/spms_pkg.sv @@
`timescale 1ns / 1ps

package spms_pkg;

	// List capacity and move width
	localparam int MAX_MOVES = 256;
	localparam int MOVE_BITS = 16;
	localparam int COUNT_W   = $clog2(MAX_MOVES + 1);

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_READ = 1'b1;

	typedef logic [MOVE_BITS-1:0] move_t;
	typedef logic [COUNT_W-1:0]   count_t;

	// Key {capture, promotion}: 3 > 2 > 1 > 0 orders as 150 > 100 > 50 > 0
	typedef logic [1:0] key_t;

	typedef struct packed {
		move_t move;
		key_t  key;
	} slot_t;

	// Broadcast from the list control to every cell
	typedef struct packed {
		logic  load_en;
		logic  pop_en;
		slot_t new_slot;
	} cell_ctrl_t;

endpackage

@@ hdl/spms_if.sv @@
`timescale 1ns / 1ps

// Request channel: load or readout items
interface spms_req_if;
	logic  valid;
	logic  ready;
	logic  mode;
	logic  [15:0] move_code;
	logic  is_capture;
	logic  promo_flag;

	modport source (output valid, mode, move_code, is_capture, promo_flag, input ready);
	modport sink   (input valid, mode, move_code, is_capture, promo_flag, output ready);
endinterface

// Response channel: one item per readout
interface spms_rsp_if;
	logic  valid;
	logic  ready;
	logic  [15:0] sorted_move;
	logic  last_move;
	logic  list_empty;
	logic  overflow;

	modport source (output valid, sorted_move, last_move, list_empty, overflow, input ready);
	modport sink   (input valid, sorted_move, last_move, list_empty, overflow, output ready);
endinterface

@@ hdl/spms_cell.sv @@
`timescale 1ns / 1ps

// One slot of the sorted row. The row is kept in descending key order, so
// "new key beats mine" is monotonic along the row and marks the insertion
// point without a search.
module spms_cell (
	input  logic                   clk,
	input  spms_pkg::cell_ctrl_t   ctrl,
	input  logic                   occupied,
	input  logic                   left_shift,
	input  spms_pkg::slot_t        left_slot,
	input  spms_pkg::slot_t        right_slot,
	output logic                   shift,
	output spms_pkg::slot_t        slot
);

	spms_pkg::slot_t slot_q;

	// Strictly greater keeps equal keys in load order
	assign shift = !occupied || (ctrl.new_slot.key > slot_q.key);
	assign slot  = slot_q;

	// Insert: first shifting cell takes the new move, the rest take the left
	// neighbor. Pop: every cell takes the right neighbor.
	always_ff @(posedge clk) begin
		if (ctrl.load_en) begin
			if (shift) begin
				slot_q <= left_shift ? left_slot : ctrl.new_slot;
			end
		end else if (ctrl.pop_en) begin
			slot_q <= right_slot;
		end
	end

endmodule

@@ hdl/stable_priority_move_sort.sv @@
`timescale 1ns / 1ps

// Stable priority move sorter. Load items (mode 0) insert a move into a row
// of spms_pkg::MAX_MOVES cells kept in descending score order (capture 100,
// promotion 50), ties in load order; readout items (mode 1) pop the head of
// the row. The insertion point is found by every cell comparing its key
// with the new one in parallel, so a load or a readout can be accepted on
// every clock. Ready drops only while a readout result sits in the output
// register and the sink does not take it. A readout of an empty list
// returns list_empty with a zero move; the final move carries last_move
// and clears the list, and a load after readout has begun starts a fresh
// list. Loads into a full list are dropped and set the overflow flag
// reported with every readout until the list clears.
module stable_priority_move_sort (
	input  logic        clk,
	input  logic        arst_n,
	spms_req_if.sink    req,
	spms_rsp_if.source  rsp
);

	localparam int N = spms_pkg::MAX_MOVES;

	spms_pkg::count_t      count_q;
	logic                  reading_q;
	logic                  ovf_q;
	logic                  rsp_valid_q;
	logic [15:0]           move_q;
	logic                  last_q;
	logic                  empty_q;
	logic                  rsp_ovf_q;

	spms_pkg::count_t      eff_count;
	logic                  accept;
	logic                  is_load;
	logic                  is_read;
	logic                  full;
	spms_pkg::cell_ctrl_t  ctrl;

	spms_pkg::slot_t       slots  [N];
	logic                  shifts [N];

	// Handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign is_load   = accept && (req.mode == spms_pkg::MODE_LOAD);
	assign is_read   = accept && (req.mode == spms_pkg::MODE_READ);

	// A load after readout began sees an empty list
	assign eff_count = reading_q ? '0 : count_q;
	assign full      = (eff_count == spms_pkg::count_t'(N));

	// Cell control
	always_comb begin
		ctrl.load_en           = is_load && !full;
		ctrl.pop_en            = is_read && (count_q != '0);
		ctrl.new_slot.move     = req.move_code[spms_pkg::MOVE_BITS-1:0];
		ctrl.new_slot.key      = {req.is_capture, req.promo_flag};
	end

	// Row of cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		spms_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (spms_pkg::count_t'(i) < eff_count),
			.left_shift ((i == 0) ? 1'b0 : shifts[(i == 0) ? 0 : i-1]),
			.left_slot  ((i == 0) ? ctrl.new_slot : slots[(i == 0) ? 0 : i-1]),
			.right_slot ((i == N-1) ? slots[i] : slots[(i == N-1) ? i : i+1]),
			.shift      (shifts[i]),
			.slot       (slots[i])
		);
	end

	// List state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			reading_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (is_load) begin
			if (reading_q) begin
				count_q   <= spms_pkg::count_t'(1);
				reading_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else if (full) begin
				ovf_q     <= 1'b1;
			end else begin
				count_q   <= count_q + spms_pkg::count_t'(1);
			end
		end else if (is_read && (count_q != '0)) begin
			if (count_q == spms_pkg::count_t'(1)) begin
				count_q   <= '0;
				reading_q <= 1'b0;
				ovf_q     <= 1'b0;
			end else begin
				count_q   <= count_q - spms_pkg::count_t'(1);
				reading_q <= 1'b1;
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (is_read) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (is_read) begin
			move_q    <= (count_q == '0) ? '0 : 16'(slots[0].move);
			last_q    <= (count_q == spms_pkg::count_t'(1));
			empty_q   <= (count_q == '0);
			rsp_ovf_q <= ovf_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.sorted_move = move_q;
	assign rsp.last_move   = last_q;
	assign rsp.list_empty  = empty_q;
	assign rsp.overflow    = rsp_ovf_q;

endmodule

@@ tb/sv/stable_priority_move_sort_test.sv @@
`timescale 1ns / 1ps

module stable_priority_move_sort_test;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET  = 750;

	typedef struct {
		logic            mode;
		spms_pkg::move_t code;
		logic            capture;
		logic            promotion;
	} request_t;

	typedef struct {
		spms_pkg::move_t move;
		logic            last;
		logic            empty;
		logic            overflow;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n;

	spms_req_if req_ch ();
	spms_rsp_if rsp_ch ();

	stable_priority_move_sort i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the move list
	spms_pkg::move_t list_moves[$];
	spms_pkg::key_t  list_keys[$];
	int    read_rank     = 0;
	logic  readout_begun = 1'b0;
	logic  dropped_load  = 1'b0;

	request_t request_queue[$];
	readout_t expected_readouts[$];
	request_t current_req;
	logic     holding    = 1'b0;
	logic     send_calm  = 1'b0;
	logic     recv_calm  = 1'b0;
	int       send_gap   = 0;
	int       recv_gap   = 0;
	int       mismatches = 0;
	int       cycle_count = 0;
	int       item_total = 0;

	always #5 clk = ~clk;

	// Wait before the next item; calm stretches have no waits at all
	function automatic int draw_wait(ref logic calm);
		if ($urandom_range(0, 39) == 0)
			calm = ~calm;
		return calm ? 0 : $urandom_range(0, 6);
	endfunction

	function automatic void clear_list();
		list_moves.delete();
		list_keys.delete();
		read_rank     = 0;
		readout_begun = 1'b0;
		dropped_load  = 1'b0;
	endfunction

	// Move at a rank of the descending key order, load order among equal keys
	function automatic spms_pkg::move_t move_of_rank(int rank);
		int left = rank;
		for (int k = 3; k >= 0; k--) begin
			for (int i = 0; i < list_moves.size(); i++) begin
				if (list_keys[i] == spms_pkg::key_t'(k)) begin
					if (left == 0)
						return list_moves[i];
					left--;
				end
			end
		end
		return '0;
	endfunction

	// Update the shadow list for one accepted item; readouts queue a result
	function automatic void track_request(request_t r);
		readout_t res;
		if (r.mode == spms_pkg::MODE_LOAD) begin
			if (readout_begun)
				clear_list();
			if (list_moves.size() < spms_pkg::MAX_MOVES) begin
				list_moves.push_back(r.code);
				list_keys.push_back({r.capture, r.promotion});
			end else begin
				dropped_load = 1'b1;
			end
		end else if (list_moves.size() == 0) begin
			res = '{move: '0, last: 1'b0, empty: 1'b1, overflow: dropped_load};
			expected_readouts.push_back(res);
		end else begin
			readout_begun = 1'b1;
			res.move     = move_of_rank(read_rank);
			res.last     = (read_rank + 1 >= list_moves.size());
			res.empty    = 1'b0;
			res.overflow = dropped_load;
			expected_readouts.push_back(res);
			if (res.last)
				clear_list();
			else
				read_rank++;
		end
	endfunction

	function automatic void add_load(spms_pkg::move_t code, logic capture, logic promotion);
		request_queue.push_back('{mode: spms_pkg::MODE_LOAD, code: code, capture: capture,
			promotion: promotion});
		item_total++;
	endfunction

	function automatic void add_read();
		request_queue.push_back('{mode: spms_pkg::MODE_READ,
			code: spms_pkg::move_t'($urandom_range(0, 65535)),
			capture: 1'($urandom), promotion: 1'($urandom)});
		item_total++;
	endfunction

	task automatic note_mismatch(string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic check_readout();
		readout_t want;
		if (expected_readouts.size() == 0) begin
			note_mismatch($sformatf("readout %h with none expected", rsp_ch.sorted_move));
			return;
		end
		want = expected_readouts.pop_front();
		if (rsp_ch.sorted_move !== want.move)
			note_mismatch($sformatf("sorted_move %h, expected %h", rsp_ch.sorted_move, want.move));
		if (rsp_ch.last_move !== want.last)
			note_mismatch($sformatf("last_move %b, expected %b", rsp_ch.last_move, want.last));
		if (rsp_ch.list_empty !== want.empty)
			note_mismatch($sformatf("list_empty %b, expected %b", rsp_ch.list_empty, want.empty));
		if (rsp_ch.overflow !== want.overflow)
			note_mismatch($sformatf("overflow %b, expected %b", rsp_ch.overflow, want.overflow));
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.mode       <= spms_pkg::MODE_LOAD;
			req_ch.move_code  <= '0;
			req_ch.is_capture <= 1'b0;
			req_ch.promo_flag <= 1'b0;
			holding  = 1'b0;
			send_gap = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				track_request(current_req);
				holding  = 1'b0;
				send_gap = draw_wait(send_calm);
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_queue.size() > 0) begin
					current_req = request_queue.pop_front();
					holding     = 1'b1;
				end
			end
			req_ch.valid <= holding;
			if (holding) begin
				req_ch.mode       <= current_req.mode;
				req_ch.move_code  <= current_req.code;
				req_ch.is_capture <= current_req.capture;
				req_ch.promo_flag <= current_req.promotion;
			end
		end
	end

	// Readout monitor with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				check_readout();
				recv_gap = draw_wait(recv_calm);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int list_idx;
		int n;
		int stored;
		int reads;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = spms_pkg::MODE_LOAD;
		req_ch.move_code  = '0;
		req_ch.is_capture = 1'b0;
		req_ch.promo_flag = 1'b0;
		rsp_ch.ready      = 1'b0;

		// Directed: empty readout, all keys, extreme codes, load mid-readout,
		// single-move list
		add_read();
		add_load(16'h0000, 1'b0, 1'b0);
		add_load(16'hFFFF, 1'b1, 1'b1);
		add_load(16'h8001, 1'b0, 1'b1);
		add_load(16'h7FFE, 1'b1, 1'b0);
		add_load(16'h1234, 1'b1, 1'b1);
		add_load(16'h5555, 1'b0, 1'b0);
		add_load(16'hAAAA, 1'b1, 1'b0);
		repeat (3) add_read();
		add_load(16'hC3C3, 1'b1, 1'b0);
		add_load(16'h3C3C, 1'b0, 1'b1);
		repeat (3) add_read();
		add_load(16'hFFFF, 1'b0, 1'b0);
		add_read();

		// Random lists; two of them overfill the store, the second is cut short
		list_idx = 0;
		while (item_total < ITEM_TARGET) begin
			if (list_idx == 1 || list_idx == 3)
				n = spms_pkg::MAX_MOVES + $urandom_range(1, 4);
			else if ($urandom_range(0, 9) == 0)
				n = 0;
			else
				n = $urandom_range(1, 12);
			repeat (n)
				add_load(spms_pkg::move_t'($urandom_range(0, 65535)), 1'($urandom),
					1'($urandom));
			stored = (n < spms_pkg::MAX_MOVES) ? n : spms_pkg::MAX_MOVES;
			case ($urandom_range(0, 4))
				0: reads = $urandom_range(1, (stored > 0) ? stored : 1);
				1: reads = stored + $urandom_range(1, 2);
				default: reads = stored;
			endcase
			if (list_idx == 3)
				reads = $urandom_range(1, 5);
			repeat (reads) add_read();
			list_idx++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || holding || expected_readouts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
